### hdl/msbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte signature scan: shared types and constants
// Holds the configuration bundle, the queue item passed from the front end to
// the back end, the register index codes and the fixed region limits.
// ----------------------------------------------------------------------------
package msbs_pkg;

    // Register index codes of the configuration port.
    localparam logic [2:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [2:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [2:0] CFG_CARE_MASK      = 3'd2;
    localparam logic [2:0] CFG_PATTERN_LENGTH = 3'd3;
    localparam logic [2:0] CFG_SCAN_REGION    = 3'd4;
    localparam logic [2:0] CFG_ENTRY_OFFSET   = 3'd5;
    localparam logic [2:0] CFG_OVERLAY_OFFSET = 3'd6;
    localparam logic [2:0] CFG_OVERLAY_LEN    = 3'd7;

    // Scan region codes; the unused code behaves as the whole-file scan.
    localparam logic [1:0] REGION_ENTRY   = 2'd0;
    localparam logic [1:0] REGION_OVERLAY = 2'd1;
    localparam logic [1:0] REGION_WHOLE   = 2'd2;

    // Hits may start at most this far into the file or into the tail/overlay.
    localparam logic [31:0] SCAN_CAP  = 32'd8388608;
    // Length of the tail section at the end of the file.
    localparam logic [31:0] TAIL_SPAN = 32'd65536;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [15:0] care_mask;
        logic [4:0]  pattern_length;
        logic [1:0]  scan_region;
        logic [31:0] entry_offset;
        logic [31:0] overlay_offset;
        logic [31:0] overlay_len;
    } t_scan_cfg;

    // One classified byte: whether a match completed at it, where that match
    // started, how many bytes have been taken so far and whether it ends the file.
    typedef struct packed {
        logic        hit;
        logic        last;
        logic [31:0] start;
        logic [31:0] count;
    } t_scan_item;

endpackage

### hdl/msbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte signature scan: front end
// Keeps the sliding byte window and the byte count, and runs the masked
// compare for every pattern length at once, tagging each byte with its hit.
// ----------------------------------------------------------------------------
module msbs_front #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  msbs_pkg::t_scan_cfg   i_cfg,
    input  logic                  i_valid,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    output logic                  o_ready,
    output logic                  o_valid,
    output msbs_pkg::t_scan_item  o_item,
    input  logic                  i_queue_ready,
    output logic [4:0]            o_used_len
);

    logic [7:0]             r_window [MAX_PATTERN];
    logic [7:0]             n_window [MAX_PATTERN];
    logic [31:0]            r_count;
    logic [31:0]            n_count;
    logic [MAX_PATTERN-1:0] len_match;
    logic                   sel_match;
    logic                   accept;
    logic [127:0]           pattern;

    assign pattern  = {i_cfg.pattern_high, i_cfg.pattern_low};
    assign o_ready  = i_queue_ready;
    assign accept   = i_valid && i_queue_ready;

    assign o_used_len = (i_cfg.pattern_length > 5'(MAX_PATTERN)) ?
                        5'(MAX_PATTERN) : i_cfg.pattern_length;

    // The window after this byte; the newest byte sits at the top index.
    always_comb begin
        for (int j = 0; j < MAX_PATTERN - 1; j++) begin
            n_window[j] = r_window[j + 1];
        end
        n_window[MAX_PATTERN - 1] = i_data_byte;
    end

    assign n_count = (r_count == '1) ? r_count : r_count + 32'd1;

    // One compare result per possible pattern length, over the newest bytes.
    always_comb begin
        for (int k = 1; k <= MAX_PATTERN; k++) begin
            len_match[k - 1] = 1'b1;
            for (int i = 0; i < k; i++) begin
                if (i_cfg.care_mask[i] &&
                    n_window[MAX_PATTERN - k + i] != pattern[8 * i +: 8]) begin
                    len_match[k - 1] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        sel_match = 1'b0;
        for (int k = 1; k <= MAX_PATTERN; k++) begin
            if (o_used_len == 5'(k)) begin
                sel_match = len_match[k - 1];
            end
        end
    end

    assign o_valid      = accept;
    assign o_item.hit   = sel_match && (n_count >= {27'd0, o_used_len});
    assign o_item.last  = i_last_byte;
    assign o_item.start = n_count - {27'd0, o_used_len};
    assign o_item.count = n_count;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= i_last_byte ? 32'd0 : n_count;
        end
    end

endmodule

### hdl/msbs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte signature scan: item queue
// A short first-in first-out buffer of classified bytes between the front
// end and the back end.
// ----------------------------------------------------------------------------
module msbs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  msbs_pkg::t_scan_item  i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output msbs_pkg::t_scan_item  o_item,
    input  logic                  i_ready
);

    localparam int PTR_W = msbs_pkg::QUEUE_PTR_W;
    localparam int CNT_W = PTR_W + 1;

    msbs_pkg::t_scan_item r_mem [msbs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;
    logic                 push;
    logic                 pop;

    assign o_ready = (r_count != CNT_W'(msbs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(msbs_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_push_only_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue count did not grow on push");

    a_pop_only_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("queue count did not shrink on pop");
`endif

endmodule

### hdl/msbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte signature scan: back end
// Sorts each hit into the entry, early, tail and overlay regions, settles the
// verdict at the last byte of the file and holds it in the output register.
// ----------------------------------------------------------------------------
module msbs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  msbs_pkg::t_scan_cfg   i_cfg,
    input  logic [4:0]            i_used_len,
    input  logic                  i_valid,
    input  msbs_pkg::t_scan_item  i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic                  o_found,
    input  logic                  i_ready
);

    // Region limits, refreshed every cycle from the settled registers.
    logic        r_ovl_en;
    logic [32:0] r_ovl_lim;
    logic [32:0] r_ovl_capo;
    logic [32:0] r_ovl_end;

    logic        r_early;
    logic        r_late_valid;
    logic [31:0] r_late;
    logic        r_ovl;
    logic        r_out_valid;
    logic        r_found;

    logic        mode_entry;
    logic        mode_overlay;
    logic        pop;
    logic        n_early;
    logic        n_late_valid;
    logic [31:0] n_late;
    logic        n_ovl;
    logic        ovl_ok;
    logic        tail_ok;
    logic [32:0] late_plus_tail;
    logic [32:0] count_ext;
    logic        n_found;

    assign mode_entry   = (i_cfg.scan_region == msbs_pkg::REGION_ENTRY);
    assign mode_overlay = (i_cfg.scan_region == msbs_pkg::REGION_OVERLAY);

    assign o_ready = !i_item.last || !r_out_valid || i_ready;
    assign pop     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        r_ovl_en   <= (i_cfg.overlay_len != 32'd0) &&
                      (i_cfg.overlay_len >= {27'd0, i_used_len});
        r_ovl_lim  <= {1'b0, i_cfg.overlay_offset} + {1'b0, i_cfg.overlay_len}
                      - {28'd0, i_used_len};
        r_ovl_capo <= {1'b0, i_cfg.overlay_offset} + {1'b0, msbs_pkg::SCAN_CAP};
        r_ovl_end  <= {1'b0, i_cfg.overlay_offset} + {1'b0, i_cfg.overlay_len};
    end

    always_comb begin
        n_early      = r_early;
        n_late_valid = r_late_valid;
        n_late       = r_late;
        n_ovl        = r_ovl;
        if (i_item.hit) begin
            if (mode_entry) begin
                n_early = r_early || (i_item.start == i_cfg.entry_offset);
            end else begin
                n_early      = r_early ||
                               (!mode_overlay && i_item.start <= msbs_pkg::SCAN_CAP);
                n_late_valid = 1'b1;
                n_late       = i_item.start;
                n_ovl        = r_ovl || (r_ovl_en &&
                               i_item.start >= i_cfg.overlay_offset &&
                               {1'b0, i_item.start} <= r_ovl_lim &&
                               {1'b0, i_item.start} <= r_ovl_capo);
            end
        end
    end

    assign count_ext      = {1'b0, i_item.count};
    assign late_plus_tail = {1'b0, n_late} + {1'b0, msbs_pkg::TAIL_SPAN};
    assign ovl_ok  = (i_cfg.overlay_len != 32'd0) && (r_ovl_end <= count_ext) && n_ovl;
    assign tail_ok = n_late_valid && (i_item.count > msbs_pkg::TAIL_SPAN) &&
                     (late_plus_tail >= count_ext) &&
                     (late_plus_tail <= count_ext + {1'b0, msbs_pkg::SCAN_CAP});

    always_comb begin
        if (mode_entry) begin
            n_found = n_early;
        end else if (mode_overlay) begin
            n_found = ovl_ok;
        end else begin
            n_found = n_early || ovl_ok || tail_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_early      <= 1'b0;
            r_late_valid <= 1'b0;
            r_late       <= '0;
            r_ovl        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                if (i_item.last) begin
                    r_early      <= 1'b0;
                    r_late_valid <= 1'b0;
                    r_late       <= '0;
                    r_ovl        <= 1'b0;
                end else begin
                    r_early      <= n_early;
                    r_late_valid <= n_late_valid;
                    r_late       <= n_late;
                    r_ovl        <= n_ovl;
                end
            end
            if (pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_item.last) begin
            r_found <= n_found;
        end
    end

    assign o_valid = r_out_valid;
    assign o_found = r_found;

`ifndef SYNTH
    a_file_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_item.last |=> !r_early && !r_late_valid && !r_ovl && r_out_valid)
        else $error("file state not cleared at the last byte");

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result pending after reset");
`endif

endmodule

### hdl/masked_byte_signature_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte signature scan: top level
// Streams a file one byte at a time and reports at its last byte whether a
// masked pattern of up to sixteen bytes was found in the selected region.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock cycle while the queue has room; the
// limit is the combinational window compare in the front end. A four-entry
// queue sits between the front end, which shifts the byte window and runs the
// masked compare, and the back end, which sorts each hit into the entry,
// early, tail and overlay regions. One result request (found in bit 0 of
// m_axis_tdata) is produced for each file once the tlast byte has passed the
// queue; it waits in an output register while input keeps flowing until the
// queue fills. The user must write the registers through the plain write
// port only while the block is idle; the block does not enforce this. The
// file state clears after every last byte while the registers are kept.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan #(
    parameter int MAX_PATTERN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    // File byte requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // Result requests
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] found, [7:1] zero
);

    msbs_pkg::t_scan_cfg  r_cfg;
    msbs_pkg::t_scan_item front_item;
    msbs_pkg::t_scan_item queue_item;
    logic                 front_valid;
    logic                 queue_ready;
    logic                 queue_valid;
    logic                 back_ready;
    logic [4:0]           used_len;
    logic                 found;

    // Register bank. Each write keeps only the bits its register holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low    <= '0;
            r_cfg.pattern_high   <= '0;
            r_cfg.care_mask      <= '0;
            r_cfg.pattern_length <= '0;
            r_cfg.scan_region    <= msbs_pkg::REGION_WHOLE;
            r_cfg.entry_offset   <= '0;
            r_cfg.overlay_offset <= '0;
            r_cfg.overlay_len    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                msbs_pkg::CFG_PATTERN_LOW:    r_cfg.pattern_low    <= i_cfg_wdata;
                msbs_pkg::CFG_PATTERN_HIGH:   r_cfg.pattern_high   <= i_cfg_wdata;
                msbs_pkg::CFG_CARE_MASK:      r_cfg.care_mask      <= i_cfg_wdata[15:0];
                msbs_pkg::CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_wdata[4:0];
                msbs_pkg::CFG_SCAN_REGION:    r_cfg.scan_region    <= i_cfg_wdata[1:0];
                msbs_pkg::CFG_ENTRY_OFFSET:   r_cfg.entry_offset   <= i_cfg_wdata[31:0];
                msbs_pkg::CFG_OVERLAY_OFFSET: r_cfg.overlay_offset <= i_cfg_wdata[31:0];
                msbs_pkg::CFG_OVERLAY_LEN:    r_cfg.overlay_len    <= i_cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: window, byte count and the masked compare.
    msbs_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .i_data_byte   (s_axis_tdata),
        .i_last_byte   (s_axis_tlast),
        .o_ready       (s_axis_tready),
        .o_valid       (front_valid),
        .o_item        (front_item),
        .i_queue_ready (queue_ready),
        .o_used_len    (used_len)
    );

    // Queue of classified bytes so either side can stall on its own.
    msbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_ready (back_ready)
    );

    // Back end: region sorting and the verdict at the end of the file.
    msbs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_used_len (used_len),
        .i_valid    (queue_valid),
        .i_item     (queue_item),
        .o_ready    (back_ready),
        .o_valid    (m_axis_tvalid),
        .o_found    (found),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, found};

endmodule
